// ===== design/rbsi_pkg.sv =====
// Package with shared types and constants for the ray box slab intersect block.
`timescale 1ns / 1ps
`default_nettype none
package rbsi_pkg;
   localparam int COORD_WIDTH = 32;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] box_min_x;
      logic signed [COORD_WIDTH-1:0] box_min_y;
      logic signed [COORD_WIDTH-1:0] box_min_z;
      logic signed [COORD_WIDTH-1:0] box_max_x;
      logic signed [COORD_WIDTH-1:0] box_max_y;
      logic signed [COORD_WIDTH-1:0] box_max_z;
      logic signed [COORD_WIDTH-1:0] origin_x;
      logic signed [COORD_WIDTH-1:0] origin_y;
      logic signed [COORD_WIDTH-1:0] origin_z;
      logic signed [COORD_WIDTH-1:0] dir_x;
      logic signed [COORD_WIDTH-1:0] dir_y;
      logic signed [COORD_WIDTH-1:0] dir_z;
   } req_type;

   typedef struct packed {
      logic                          hit;
      logic signed [COORD_WIDTH-1:0] t_enter;
      logic signed [COORD_WIDTH-1:0] t_exit;
   } rsp_type;

   typedef struct packed {
      logic zero;
      logic outside;
      logic dneg;
   } axis_flag_type;

   typedef struct packed {
      logic                          no_limit;
      logic                          miss;
      logic signed [COORD_WIDTH-1:0] t_near;
      logic signed [COORD_WIDTH-1:0] t_far;
   } axis_res_type;
endpackage
`default_nettype wire

// ===== design/rbsi_div.sv =====
// Pipelined saturating fixed-point divider, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module rbsi_div #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                                 clock,
   input  wire logic [rbsi_pkg::COORD_WIDTH+1:0]     en,
   input  wire logic signed [rbsi_pkg::COORD_WIDTH:0] num,
   input  wire logic signed [rbsi_pkg::COORD_WIDTH-1:0] den,
   output logic signed [rbsi_pkg::COORD_WIDTH-1:0]   quo
);
   import rbsi_pkg::*;
   localparam int CW = COORD_WIDTH;

   logic [CW:0]             a;
   logic [CW-1:0]           b;
   logic [CW:0]             hi;
   logic [CW+FRAC_BITS:0]   ash;
   logic [CW-1:0]           r_ff [0:CW];
   logic [CW-1:0]           r_in [0:CW];
   logic [CW-1:0]           n_ff [0:CW];
   logic [CW-1:0]           n_in [0:CW];
   logic [CW-1:0]           q_ff [0:CW];
   logic [CW-1:0]           q_in [0:CW];
   logic [CW-1:0]           b_ff [0:CW];
   logic                    ovf_ff [0:CW];
   logic                    ovf_in;
   logic                    neg_ff [0:CW];
   logic                    neg_in;
   logic [CW:0]             rs [0:CW-1];
   logic [CW-1:0]           lim;
   logic [CW-1:0]           mag;
   logic signed [CW-1:0]    quo_ff;
   logic signed [CW-1:0]    quo_in;

   always_comb begin
      a      = num[CW] ? (~num + 1'b1) : num;
      b      = den[CW-1] ? (~den + 1'b1) : den;
      neg_in = num[CW] ^ den[CW-1];
      hi     = a >> (CW - FRAC_BITS);
      ovf_in = hi >= {1'b0, b};
      ash    = {a, {FRAC_BITS{1'b0}}};
      r_in[0] = hi[CW-1:0];
      n_in[0] = ash[CW-1:0];
      q_in[0] = '0;
      for (int k = 0; k < CW; k++) begin
         rs[k] = {r_ff[k], n_ff[k][CW-1]};
         if (rs[k] >= {1'b0, b_ff[k]}) begin
            r_in[k+1] = CW'(rs[k] - {1'b0, b_ff[k]});
            q_in[k+1] = {q_ff[k][CW-2:0], 1'b1};
         end else begin
            r_in[k+1] = rs[k][CW-1:0];
            q_in[k+1] = {q_ff[k][CW-2:0], 1'b0};
         end
         n_in[k+1] = {n_ff[k][CW-2:0], 1'b0};
      end
      lim = neg_ff[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      mag = (ovf_ff[CW] || (q_ff[CW] > lim)) ? lim : q_ff[CW];
      quo_in = neg_ff[CW] ? -$signed(mag) : $signed(mag);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         r_ff[0]   <= r_in[0];
         n_ff[0]   <= n_in[0];
         q_ff[0]   <= q_in[0];
         b_ff[0]   <= b;
         ovf_ff[0] <= ovf_in;
         neg_ff[0] <= neg_in;
      end
      for (int k = 0; k < CW; k++) begin
         if (en[k+1]) begin
            r_ff[k+1]   <= r_in[k+1];
            n_ff[k+1]   <= n_in[k+1];
            q_ff[k+1]   <= q_in[k+1];
            b_ff[k+1]   <= b_ff[k];
            ovf_ff[k+1] <= ovf_ff[k];
            neg_ff[k+1] <= neg_ff[k];
         end
      end
      if (en[CW+1]) begin
         quo_ff <= quo_in;
      end
   end

   assign quo = quo_ff;
endmodule
`default_nettype wire

// ===== design/rbsi_axis.sv =====
// One axis of the slab test: plane offsets, two dividers and the swap.
`timescale 1ns / 1ps
`default_nettype none
module rbsi_axis #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                                   clock,
   input  wire logic [rbsi_pkg::COORD_WIDTH+2:0]       en,
   input  wire logic signed [rbsi_pkg::COORD_WIDTH-1:0] lo,
   input  wire logic signed [rbsi_pkg::COORD_WIDTH-1:0] hi,
   input  wire logic signed [rbsi_pkg::COORD_WIDTH-1:0] org,
   input  wire logic signed [rbsi_pkg::COORD_WIDTH-1:0] dir,
   output rbsi_pkg::axis_res_type                      res
);
   import rbsi_pkg::*;
   localparam int CW = COORD_WIDTH;

   logic signed [CW:0]   dlo_ff;
   logic signed [CW:0]   dlo_in;
   logic signed [CW:0]   dhi_ff;
   logic signed [CW:0]   dhi_in;
   logic signed [CW-1:0] d_ff;
   axis_flag_type        fl_ff [0:CW+2];
   axis_flag_type        fl_in;
   logic signed [CW-1:0] t_lo;
   logic signed [CW-1:0] t_hi;

   always_comb begin
      dlo_in        = {lo[CW-1], lo} - {org[CW-1], org};
      dhi_in        = {hi[CW-1], hi} - {org[CW-1], org};
      fl_in.zero    = dir == '0;
      fl_in.outside = (org < lo) || (org > hi);
      fl_in.dneg    = dir[CW-1];
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         dlo_ff   <= dlo_in;
         dhi_ff   <= dhi_in;
         d_ff     <= dir;
         fl_ff[0] <= fl_in;
      end
      for (int j = 1; j <= CW + 2; j++) begin
         if (en[j]) begin
            fl_ff[j] <= fl_ff[j-1];
         end
      end
   end

   rbsi_div #(.FRAC_BITS(FRAC_BITS)) u_div_lo (
      .clock (clock),
      .en    (en[CW+2:1]),
      .num   (dlo_ff),
      .den   (d_ff),
      .quo   (t_lo)
   );

   rbsi_div #(.FRAC_BITS(FRAC_BITS)) u_div_hi (
      .clock (clock),
      .en    (en[CW+2:1]),
      .num   (dhi_ff),
      .den   (d_ff),
      .quo   (t_hi)
   );

   always_comb begin
      res.no_limit = fl_ff[CW+2].zero;
      res.miss     = fl_ff[CW+2].zero && fl_ff[CW+2].outside;
      res.t_near   = fl_ff[CW+2].dneg ? t_hi : t_lo;
      res.t_far    = fl_ff[CW+2].dneg ? t_lo : t_hi;
   end
endmodule
`default_nettype wire

// ===== design/ray_box_slab_intersect.sv =====
// Top level of the ray versus axis-aligned box slab intersection pipeline.
// Usage:
//   Present one ray and one box per transaction on the req_ channel; a
//   transaction is taken at a rising edge with req_valid high and req_stall
//   low. Each transaction yields exactly one result on the rsp_ channel:
//   hit, entry distance and exit distance in signed Q16.16, both zero on a
//   miss. Distances saturate at the extremes of the coordinate range.
//   The pipeline registers the plane offsets, passes them through the per-axis
//   dividers, which produce one quotient bit per stage, and merges the axes
//   in the tmin/tmax registers and then in the result register.
//   Throughput is one transaction per cycle while the pipeline is not held
//   by rsp_stall; all six divisions run in parallel pipelines.
//   When the receiver raises rsp_stall, the result held on rsp_data stays;
//   empty stages behind it keep filling, and req_stall rises only once every
//   stage holds a transaction.
//   Synchronous reset empties the pipeline; no result is shown until new
//   transactions arrive.
`timescale 1ns / 1ps
`default_nettype none
module ray_box_slab_intersect #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire rbsi_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output rbsi_pkg::rsp_type      rsp_data
);
   import rbsi_pkg::*;
   localparam int CW  = COORD_WIDTH;
   localparam int NST = CW + 5;

   logic [NST-1:0]       v_ff;
   logic [NST-1:0]       v_in;
   logic [NST:0]         adv;
   axis_res_type         ax [0:2];
   logic signed [CW-1:0] tmin_in;
   logic signed [CW-1:0] tmax_in;
   logic                 miss_in;
   logic signed [CW-1:0] tmin_ff;
   logic signed [CW-1:0] tmax_ff;
   logic                 miss_ff;
   rsp_type              rsp_ff;
   rsp_type              rsp_in;
   logic                 hit;

   always_comb begin
      adv[NST] = !rsp_stall;
      for (int i = NST - 1; i >= 0; i--) begin
         adv[i] = !v_ff[i] || adv[i+1];
      end
      v_in[0] = req_valid;
      for (int i = 1; i < NST; i++) begin
         v_in[i] = v_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int i = 0; i < NST; i++) begin
            if (adv[i]) begin
               v_ff[i] <= v_in[i];
            end
         end
      end
   end

   rbsi_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_x (
      .clock (clock),
      .en    (adv[CW+2:0]),
      .lo    (req_data.box_min_x),
      .hi    (req_data.box_max_x),
      .org   (req_data.origin_x),
      .dir   (req_data.dir_x),
      .res   (ax[0])
   );

   rbsi_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_y (
      .clock (clock),
      .en    (adv[CW+2:0]),
      .lo    (req_data.box_min_y),
      .hi    (req_data.box_max_y),
      .org   (req_data.origin_y),
      .dir   (req_data.dir_y),
      .res   (ax[1])
   );

   rbsi_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_z (
      .clock (clock),
      .en    (adv[CW+2:0]),
      .lo    (req_data.box_min_z),
      .hi    (req_data.box_max_z),
      .org   (req_data.origin_z),
      .dir   (req_data.dir_z),
      .res   (ax[2])
   );

   always_comb begin
      tmin_in = {1'b1, {(CW-1){1'b0}}};
      tmax_in = {1'b0, {(CW-1){1'b1}}};
      miss_in = 1'b0;
      for (int a = 0; a < 3; a++) begin
         if (ax[a].miss) begin
            miss_in = 1'b1;
         end
         if (!ax[a].no_limit) begin
            if (ax[a].t_near > tmin_in) begin
               tmin_in = ax[a].t_near;
            end
            if (ax[a].t_far < tmax_in) begin
               tmax_in = ax[a].t_far;
            end
         end
      end
      hit            = !miss_ff && (tmax_ff > tmin_ff);
      rsp_in.hit     = hit;
      rsp_in.t_enter = hit ? tmin_ff : '0;
      rsp_in.t_exit  = hit ? tmax_ff : '0;
   end

   always_ff @(posedge clock) begin
      if (adv[CW+3]) begin
         tmin_ff <= tmin_in;
         tmax_ff <= tmax_in;
         miss_ff <= miss_in;
      end
      if (adv[CW+4]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign req_stall = !adv[0];
   assign rsp_valid = v_ff[NST-1];
   assign rsp_data  = rsp_ff;
endmodule
`default_nettype wire

// ===== design/rbsi_checker.sv =====
// Port-level checker for the ray box slab intersect block, with its bind.
`timescale 1ns / 1ps
`default_nettype none
module rbsi_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire rbsi_pkg::req_type req_data,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire rbsi_pkg::rsp_type rsp_data
);
   import rbsi_pkg::*;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result shown right after reset");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.hit) |-> (rsp_data.t_enter == '0 && rsp_data.t_exit == '0))
      else $error("miss with nonzero distances");

   a_hit_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.hit) |-> (rsp_data.t_exit > rsp_data.t_enter))
      else $error("hit with exit not beyond entry");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled while output is free");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed");
endmodule

bind ray_box_slab_intersect rbsi_checker u_rbsi_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
`default_nettype wire

// ===== dv/ray_box_slab_intersect_test.sv =====
// Testbench for the ray box slab intersect block: directed and random rays checked in order.
`timescale 1ns / 1ps
`default_nettype none
module ray_box_slab_intersect_test;
   import rbsi_pkg::*;

   localparam int CW = COORD_WIDTH;
   localparam int FB = 16;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int RANDOM_ITEMS = 1250;
   localparam logic signed [CW-1:0] T_MIN = {1'b1, {(CW-1){1'b0}}};
   localparam logic signed [CW-1:0] T_MAX = {1'b0, {(CW-1){1'b1}}};

   class hit_scoreboard;
      rsp_type pending_hits[$];
      int errors;

      function automatic longint slab_quotient(longint num, longint den);
         logic neg;
         longint unsigned a, b, lim, q, r;
         neg = (num < 0) != (den < 0);
         a = num < 0 ? -num : num;
         b = den < 0 ? -den : den;
         lim = neg ? (64'd1 << (CW-1)) : (64'd1 << (CW-1)) - 1;
         q = a / b;
         r = a % b;
         if (q > (lim >> FB)) begin
            q = lim;
         end else begin
            for (int i = 0; i < FB; i++) begin
               r = r << 1;
               q = q << 1;
               if (r >= b) begin
                  r = r - b;
                  q = q | 1;
               end
            end
            if (q > lim) q = lim;
         end
         return neg ? -longint'(q) : longint'(q);
      endfunction

      function void note_ray(req_type ray);
         longint lo[3], hi[3], o[3], d[3];
         longint tmin, tmax, t0, t1, tmp;
         logic hit;
         rsp_type res;
         lo = '{ray.box_min_x, ray.box_min_y, ray.box_min_z};
         hi = '{ray.box_max_x, ray.box_max_y, ray.box_max_z};
         o = '{ray.origin_x, ray.origin_y, ray.origin_z};
         d = '{ray.dir_x, ray.dir_y, ray.dir_z};
         tmin = T_MIN;
         tmax = T_MAX;
         hit = 1'b1;
         for (int a = 0; a < 3; a++) begin
            if (d[a] == 0) begin
               if (o[a] < lo[a] || o[a] > hi[a]) hit = 1'b0;
               continue;
            end
            t0 = slab_quotient(lo[a] - o[a], d[a]);
            t1 = slab_quotient(hi[a] - o[a], d[a]);
            if (d[a] < 0) begin
               tmp = t0;
               t0 = t1;
               t1 = tmp;
            end
            if (t0 > tmin) tmin = t0;
            if (t1 < tmax) tmax = t1;
         end
         if (tmax <= tmin) hit = 1'b0;
         res.hit = hit;
         res.t_enter = hit ? tmin[CW-1:0] : '0;
         res.t_exit = hit ? tmax[CW-1:0] : '0;
         pending_hits.push_back(res);
      endfunction

      function void check_hit(rsp_type got);
         rsp_type want;
         if (pending_hits.size() == 0) begin
            $error("unexpected result hit=%0b t_enter=%0d t_exit=%0d",
               got.hit, got.t_enter, got.t_exit);
            errors++;
            return;
         end
         want = pending_hits.pop_front();
         if (got.hit !== want.hit) begin
            $error("hit: expected %0b actual %0b", want.hit, got.hit);
            errors++;
         end
         if (got.t_enter !== want.t_enter) begin
            $error("t_enter: expected %0d actual %0d", want.t_enter, got.t_enter);
            errors++;
         end
         if (got.t_exit !== want.t_exit) begin
            $error("t_exit: expected %0d actual %0d", want.t_exit, got.t_exit);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   hit_scoreboard board = new();
   int idle_cycles = 0;
   logic stall_enable = 1'b1;

   always #6 clock = ~clock;

   ray_box_slab_intersect dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   function automatic int gap_length();
      int p;
      p = $urandom_range(0, 99);
      if (p < 50) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) board.note_ray(req_data);
         if (rsp_valid && !rsp_stall) board.check_hit(rsp_data);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   always @(negedge clock) begin
      if (stall_enable && $urandom_range(0, 3) == 0) begin
         rsp_stall <= 1'b1;
         if ($urandom_range(0, 15) == 0) begin
            repeat ($urandom_range(10, 40)) @(negedge clock);
         end
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic send_ray(req_type ray);
      int gap;
      gap = gap_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= ray;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drop_valid();
      req_valid <= 1'b0;
   endtask

   function automatic logic [CW-1:0] pick_coord();
      case ($urandom_range(0, 5))
         0: return T_MIN;
         1: return T_MAX;
         2: return '0;
         3: return $urandom();
         default: return CW'($signed($urandom_range(0, 20 << FB)) - (10 << FB));
      endcase
   endfunction

   function automatic req_type random_ray();
      req_type r;
      logic [CW-1:0] a, b;
      r = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
           $urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
      if ($urandom_range(0, 9) < 7) begin
         a = pick_coord(); b = pick_coord();
         r.box_min_x = $signed(a) < $signed(b) ? a : b;
         r.box_max_x = $signed(a) < $signed(b) ? b : a;
         a = pick_coord(); b = pick_coord();
         r.box_min_y = $signed(a) < $signed(b) ? a : b;
         r.box_max_y = $signed(a) < $signed(b) ? b : a;
         a = pick_coord(); b = pick_coord();
         r.box_min_z = $signed(a) < $signed(b) ? a : b;
         r.box_max_z = $signed(a) < $signed(b) ? b : a;
         r.origin_x = pick_coord(); r.origin_y = pick_coord(); r.origin_z = pick_coord();
         r.dir_x = ($urandom_range(0, 5) == 0) ? '0 : pick_coord();
         r.dir_y = ($urandom_range(0, 5) == 0) ? '0 : pick_coord();
         r.dir_z = ($urandom_range(0, 5) == 0) ? '0 : pick_coord();
      end
      return r;
   endfunction

   initial begin
      req_type r;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      r = '0;
      r.box_min_x = -(1 << FB); r.box_min_y = -(1 << FB); r.box_min_z = -(1 << FB);
      r.box_max_x = 1 << FB; r.box_max_y = 1 << FB; r.box_max_z = 1 << FB;
      send_ray(r);
      r.origin_x = -(5 << FB); r.dir_x = 1 << FB;
      send_ray(r);
      r.dir_x = -(1 << FB);
      send_ray(r);
      r.origin_x = 5 << FB;
      send_ray(r);
      r.origin_x = 1 << FB; r.dir_x = '0;
      send_ray(r);
      r.origin_x = (1 << FB) + 1;
      send_ray(r);
      r.origin_x = '0; r.dir_x = 1; r.dir_y = 1; r.dir_z = 1;
      send_ray(r);
      r.origin_x = T_MIN; r.box_max_x = T_MAX; r.box_min_x = T_MIN;
      r.dir_x = T_MAX; r.dir_y = T_MIN; r.dir_z = -1;
      send_ray(r);
      r.box_min_y = 1 << FB; r.box_max_y = -(1 << FB);
      send_ray(r);
      r.dir_y = '0;
      send_ray(r);
      r = '0; r.box_min_x = T_MIN; r.box_max_x = T_MIN; r.origin_x = T_MAX; r.dir_x = 1;
      send_ray(r);
      r = {12{T_MAX}};
      send_ray(r);
      r = {12{T_MIN}};
      send_ray(r);
      r = {12{32'hFFFF_FFFF}};
      send_ray(r);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS / 2) begin
            drop_valid();
            while (board.pending_hits.size() != 0) @(negedge clock);
         end
         if (i == RANDOM_ITEMS / 4) stall_enable = 1'b0;
         if (i == RANDOM_ITEMS / 4 + 150) stall_enable = 1'b1;
         send_ray(random_ray());
      end

      drop_valid();
      while (board.pending_hits.size() != 0) @(negedge clock);
      repeat (CW + 20) @(negedge clock);
      if (board.errors == 0 && board.pending_hits.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
`default_nettype wire

// ===== files.f =====
design/rbsi_pkg.sv
design/rbsi_div.sv
design/rbsi_axis.sv
design/ray_box_slab_intersect.sv
design/rbsi_checker.sv
dv/ray_box_slab_intersect_test.sv
